### sv/bw_pkg.sv
// ----------------------------------------------------------------------------
// bw_pkg
// Shared widths, constants and helpers for the barycentric weights pipeline.
// ----------------------------------------------------------------------------
package bw_pkg;

    localparam int COORD_W  = 16;
    localparam int NUM_CRD  = 12;
    localparam int EDGE_W   = 17;
    localparam int PROD_W   = 34;
    localparam int DOT_W    = 36;
    localparam int BIG_W    = 72;
    localparam int DEN_W    = 72;
    localparam int FRAC_W   = 16;
    localparam int QBITS    = 33;
    localparam int WGT_W    = 32;
    localparam int ADDR_W   = 3;
    localparam int IDX_W    = ADDR_W - 2;

    localparam int STG_EDGE = 0;
    localparam int STG_PROD = 1;
    localparam int STG_DOT  = 2;
    localparam int STG_GRAM = 3;
    localparam int STG_DIFF = 4;
    localparam int STG_DIVS = 5;
    localparam int STG_FIN  = STG_DIVS + QBITS + 1;
    localparam int NSTG     = STG_FIN + 1;

    localparam logic [IDX_W-1:0] REG_EPS    = '0;
    localparam logic [31:0]      EPS_RESET  = 32'd4295;
    localparam logic [WGT_W-1:0] THIRD_Q16  = 32'h0000_5555;
    localparam logic signed [WGT_W+1:0] ONE_Q16 = 34'sd65536;
    localparam logic signed [WGT_W-1:0] WGT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WGT_W-1:0] WGT_MIN = 32'sh8000_0000;

    typedef logic signed [EDGE_W-1:0] edge_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [DOT_W-1:0]  dot_t;
    typedef logic signed [BIG_W-1:0]  big_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QBITS-1:0] low;
        logic [QBITS-1:0] quo;
        logic             ovf;
        logic             neg;
    } div_lane_t;

    typedef struct packed {
        div_lane_t        v;
        div_lane_t        w;
        logic [DEN_W-1:0] den;
        logic             degen;
    } div_stage_t;

    // one restoring step: bring in the next numerator bit, subtract if it fits
    function automatic div_lane_t div_step(input div_lane_t l, input logic [DEN_W-1:0] den);
        logic [DEN_W:0] t;
        logic [DEN_W:0] d;
        div_lane_t      r;
        t = {l.rem, l.low[QBITS-1]};
        d = t - {1'b0, den};
        r = l;
        r.low = {l.low[QBITS-2:0], 1'b0};
        if (t >= {1'b0, den})
        begin
            r.rem = d[DEN_W-1:0];
            r.quo = {l.quo[QBITS-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[DEN_W-1:0];
            r.quo = {l.quo[QBITS-2:0], 1'b0};
        end
        return r;
    endfunction

    // apply the sign to the quotient magnitude and clamp to Q16.16
    function automatic logic signed [WGT_W-1:0] sat_quo(input div_lane_t l);
        logic signed [WGT_W-1:0] r;
        if (l.neg)
        begin
            if (l.ovf || l.quo[QBITS-1] || (l.quo[WGT_W-1] && (l.quo[WGT_W-2:0] != '0)))
                r = WGT_MIN;
            else
                r = WGT_W'(-$signed({1'b0, l.quo}));
        end
        else
        begin
            if (l.ovf || l.quo[QBITS-1] || l.quo[WGT_W-1])
                r = WGT_MAX;
            else
                r = $signed(l.quo[WGT_W-1:0]);
        end
        return r;
    endfunction

endpackage

### sv/barycentric_weights_top.sv
// ----------------------------------------------------------------------------
// barycentric_weights_top
// Barycentric weights of a 3-D point against a triangle, fully pipelined.
// ----------------------------------------------------------------------------
// One word is taken every cycle while the output side is ready; results
// leave in input order. The depth is set by the 33-stage restoring divider
// (one quotient bit per stage, two lanes for v and w) after five stages of
// edge, dot product, Gram product and difference arithmetic. Stalls on the
// output side hold the pipeline from the back; empty stages keep filling.
// Weights are Q16.16; a determinant below degenerate_epsilon (or zero) gives
// three weights of one third and raises the degenerate flag on tuser.
module barycentric_weights_top
    import bw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_tvalid,
    output logic              s_tready,
    // point_x, point_y, point_z, vert0_x..z, vert1_x..z, vert2_x..z (16 b each)
    input  logic [191:0]      s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // weight_u, weight_v, weight_w (32 b each)
    output logic [95:0]       m_tdata,
    // degenerate
    output logic [0:0]        m_tuser
);

    logic [31:0]       eps_reg;
    logic [NSTG-1:0]   vld_reg;
    logic [NSTG-1:0]   vld_next;
    logic [NSTG:0]     en;

    logic signed [COORD_W-1:0] crd [NUM_CRD];
    edge_t e0_reg [3];
    edge_t e1_reg [3];
    edge_t e2_reg [3];
    prod_t p00_reg [3];
    prod_t p01_reg [3];
    prod_t p11_reg [3];
    prod_t p20_reg [3];
    prod_t p21_reg [3];
    dot_t  d00_reg, d01_reg, d11_reg, d20_reg, d21_reg;
    big_t  g0_reg, g1_reg, g2_reg, g3_reg, g4_reg, g5_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] vmag_reg;
    logic [DEN_W-1:0] wmag_reg;
    logic             vneg_reg;
    logic             wneg_reg;
    big_t             dd, nv, nw;
    div_stage_t       div_reg [QBITS+1];
    div_stage_t       setup;
    logic [DEN_W+FRAC_W-1:0] mv, mw;
    logic signed [WGT_W-1:0] v_s, w_s;
    logic signed [WGT_W+1:0] u_sum;
    logic signed [WGT_W-1:0] u_s;
    logic [95:0]      out_reg;
    logic             degen_reg;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_EPS) ? eps_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_EPS))
            eps_reg <= pwdata;
    end

    // stall chain: a stage loads when it is empty or the next one moves
    assign en[NSTG] = m_tready;
    genvar gk;
    generate
        for (gk = 0; gk < NSTG; gk++)
        begin : g_en
            assign en[gk] = !vld_reg[gk] || en[gk+1];
        end
    endgenerate

    assign s_tready = en[0];
    assign vld_next = {vld_reg[NSTG-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            for (int k = 0; k < NSTG; k++)
                if (en[k])
                    vld_reg[k] <= vld_next[k];
    end

    // edge vectors
    generate
        for (gk = 0; gk < NUM_CRD; gk++)
        begin : g_crd
            assign crd[gk] = s_tdata[COORD_W*gk +: COORD_W];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en[STG_EDGE])
            for (int k = 0; k < 3; k++)
            begin
                e0_reg[k] <= EDGE_W'(crd[6+k]) - EDGE_W'(crd[3+k]);
                e1_reg[k] <= EDGE_W'(crd[9+k]) - EDGE_W'(crd[3+k]);
                e2_reg[k] <= EDGE_W'(crd[k])   - EDGE_W'(crd[3+k]);
            end
    end

    // component products
    always_ff @(posedge clk)
    begin
        if (en[STG_PROD])
            for (int k = 0; k < 3; k++)
            begin
                p00_reg[k] <= PROD_W'(e0_reg[k]) * PROD_W'(e0_reg[k]);
                p01_reg[k] <= PROD_W'(e0_reg[k]) * PROD_W'(e1_reg[k]);
                p11_reg[k] <= PROD_W'(e1_reg[k]) * PROD_W'(e1_reg[k]);
                p20_reg[k] <= PROD_W'(e2_reg[k]) * PROD_W'(e0_reg[k]);
                p21_reg[k] <= PROD_W'(e2_reg[k]) * PROD_W'(e1_reg[k]);
            end
    end

    // dot products
    always_ff @(posedge clk)
    begin
        if (en[STG_DOT])
        begin
            d00_reg <= DOT_W'(p00_reg[0]) + DOT_W'(p00_reg[1]) + DOT_W'(p00_reg[2]);
            d01_reg <= DOT_W'(p01_reg[0]) + DOT_W'(p01_reg[1]) + DOT_W'(p01_reg[2]);
            d11_reg <= DOT_W'(p11_reg[0]) + DOT_W'(p11_reg[1]) + DOT_W'(p11_reg[2]);
            d20_reg <= DOT_W'(p20_reg[0]) + DOT_W'(p20_reg[1]) + DOT_W'(p20_reg[2]);
            d21_reg <= DOT_W'(p21_reg[0]) + DOT_W'(p21_reg[1]) + DOT_W'(p21_reg[2]);
        end
    end

    // Gram and cross-term products
    always_ff @(posedge clk)
    begin
        if (en[STG_GRAM])
        begin
            g0_reg <= BIG_W'(d00_reg) * BIG_W'(d11_reg);
            g1_reg <= BIG_W'(d01_reg) * BIG_W'(d01_reg);
            g2_reg <= BIG_W'(d11_reg) * BIG_W'(d20_reg);
            g3_reg <= BIG_W'(d01_reg) * BIG_W'(d21_reg);
            g4_reg <= BIG_W'(d00_reg) * BIG_W'(d21_reg);
            g5_reg <= BIG_W'(d01_reg) * BIG_W'(d20_reg);
        end
    end

    // determinant and numerators as sign and magnitude
    assign dd = g0_reg - g1_reg;
    assign nv = g2_reg - g3_reg;
    assign nw = g4_reg - g5_reg;

    always_ff @(posedge clk)
    begin
        if (en[STG_DIFF])
        begin
            den_reg  <= dd[BIG_W-1] ? DEN_W'(-dd) : DEN_W'(dd);
            vmag_reg <= nv[BIG_W-1] ? DEN_W'(-nv) : DEN_W'(nv);
            wmag_reg <= nw[BIG_W-1] ? DEN_W'(-nw) : DEN_W'(nw);
            vneg_reg <= nv[BIG_W-1];
            wneg_reg <= nw[BIG_W-1];
        end
    end

    // divider setup: high part of the scaled numerator must be below the
    // determinant, else the quotient needs more than QBITS bits
    assign mv = {vmag_reg, {FRAC_W{1'b0}}};
    assign mw = {wmag_reg, {FRAC_W{1'b0}}};

    always_comb
    begin
        setup.den   = den_reg;
        setup.degen = (den_reg < DEN_W'(eps_reg)) || (den_reg == '0);
        setup.v.rem = DEN_W'(mv[DEN_W+FRAC_W-1:QBITS]);
        setup.v.low = mv[QBITS-1:0];
        setup.v.quo = '0;
        setup.v.ovf = DEN_W'(mv[DEN_W+FRAC_W-1:QBITS]) >= den_reg;
        setup.v.neg = vneg_reg;
        setup.w.rem = DEN_W'(mw[DEN_W+FRAC_W-1:QBITS]);
        setup.w.low = mw[QBITS-1:0];
        setup.w.quo = '0;
        setup.w.ovf = DEN_W'(mw[DEN_W+FRAC_W-1:QBITS]) >= den_reg;
        setup.w.neg = wneg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_DIVS])
            div_reg[0] <= setup;
    end

    generate
        for (gk = 0; gk < QBITS; gk++)
        begin : g_div
            always_ff @(posedge clk)
            begin
                if (en[STG_DIVS+1+gk])
                begin
                    div_reg[gk+1].v     <= div_step(div_reg[gk].v, div_reg[gk].den);
                    div_reg[gk+1].w     <= div_step(div_reg[gk].w, div_reg[gk].den);
                    div_reg[gk+1].den   <= div_reg[gk].den;
                    div_reg[gk+1].degen <= div_reg[gk].degen;
                end
            end
        end
    endgenerate

    // saturate, form u, select the degenerate answer
    assign v_s   = sat_quo(div_reg[QBITS].v);
    assign w_s   = sat_quo(div_reg[QBITS].w);
    assign u_sum = ONE_Q16 - (WGT_W+2)'(v_s) - (WGT_W+2)'(w_s);
    assign u_s   = (u_sum > (WGT_W+2)'(WGT_MAX)) ? WGT_MAX :
                   (u_sum < (WGT_W+2)'(WGT_MIN)) ? WGT_MIN : u_sum[WGT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en[STG_FIN])
        begin
            degen_reg <= div_reg[QBITS].degen;
            if (div_reg[QBITS].degen)
                out_reg <= {THIRD_Q16, THIRD_Q16, THIRD_Q16};
            else
                out_reg <= {w_s, v_s, u_s};
        end
    end

    assign m_tvalid   = vld_reg[STG_FIN];
    assign m_tdata    = out_reg;
    assign m_tuser[0] = degen_reg;

endmodule

### sv/bw_checker.sv
// ----------------------------------------------------------------------------
// bw_checker
// Port-level checks for the barycentric weights pipeline.
// ----------------------------------------------------------------------------
module bw_checker
    import bw_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata,
    input logic [0:0]   m_tuser
);

    // a waiting result word stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // a free output side never blocks the input side
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled with output ready");

    // degenerate words carry one third in every weight
    a_third: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[31:0] == THIRD_Q16) &&
        (m_tdata[63:32] == THIRD_Q16) && (m_tdata[95:64] == THIRD_Q16))
        else $error("degenerate word with wrong weights");

endmodule

bind barycentric_weights_top bw_checker u_bw_checker (.*);

### test/tb_barycentric_weights_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barycentric_weights_top
// Streams triangle/point words through the weights pipeline with random
// idling on both sides and checks every result against an integer predictor.
// ----------------------------------------------------------------------------

class weight_board;
    typedef struct {
        logic [31:0] u;
        logic [31:0] v;
        logic [31:0] w;
        logic        degen;
    } weights_t;

    weights_t    pending[$];
    logic [31:0] eps;
    int          errors;
    int          checked;
    int          degen_seen;

    function new();
        eps = 32'd4295;
        errors = 0;
        checked = 0;
        degen_seen = 0;
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endfunction

    // (num * 2^16) / den, truncated toward zero, clamped to Q16.16
    function logic signed [63:0] quotient(logic signed [127:0] num,
                                          logic [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = num[127] ? -num : num;
        q = (mag << 16) / den;
        if (num[127])
            return (q > 128'h8000_0000) ? -64'sh8000_0000 : -$signed({64'd0, q[63:0]});
        return (q > 128'h7FFF_FFFF) ? 64'sh7FFF_FFFF : $signed(q[63:0]);
    endfunction

    function void note_input(logic [191:0] d);
        logic signed [63:0]  crd[12];
        logic signed [63:0]  e0[3];
        logic signed [63:0]  e1[3];
        logic signed [63:0]  e2[3];
        logic signed [63:0]  d00, d01, d11, d20, d21, v, w, u;
        logic signed [127:0] gram;
        logic [127:0]        den;
        weights_t            r;
        for (int k = 0; k < 12; k++)
            crd[k] = $signed(d[16*k +: 16]);
        d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
        for (int k = 0; k < 3; k++)
        begin
            e0[k] = crd[6+k] - crd[3+k];
            e1[k] = crd[9+k] - crd[3+k];
            e2[k] = crd[k] - crd[3+k];
            d00 += e0[k] * e0[k];
            d01 += e0[k] * e1[k];
            d11 += e1[k] * e1[k];
            d20 += e2[k] * e0[k];
            d21 += e2[k] * e1[k];
        end
        gram = 128'(d00) * 128'(d11) - 128'(d01) * 128'(d01);
        den = gram[127] ? -gram : gram;
        if (den < {96'd0, eps} || den == 0)
        begin
            r.u = 32'h5555; r.v = 32'h5555; r.w = 32'h5555; r.degen = 1'b1;
        end
        else
        begin
            v = quotient(128'(d11) * 128'(d20) - 128'(d01) * 128'(d21), den);
            w = quotient(128'(d00) * 128'(d21) - 128'(d01) * 128'(d20), den);
            u = 64'sd65536 - v - w;
            if (u > 64'sh7FFF_FFFF) u = 64'sh7FFF_FFFF;
            if (u < -64'sh8000_0000) u = -64'sh8000_0000;
            r.u = u[31:0]; r.v = v[31:0]; r.w = w[31:0]; r.degen = 1'b0;
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic [95:0] d, logic deg);
        weights_t e;
        if (pending.size() == 0)
        begin
            report("unexpected word", d[31:0], 32'd0);
            return;
        end
        e = pending.pop_front();
        checked++;
        if (deg) degen_seen++;
        if (d[31:0] !== e.u) report("weight_u", d[31:0], e.u);
        if (d[63:32] !== e.v) report("weight_v", d[63:32], e.v);
        if (d[95:64] !== e.w) report("weight_w", d[95:64], e.w);
        if (deg !== e.degen) report("degenerate", {31'd0, deg}, {31'd0, e.degen});
    endfunction
endclass

module tb_barycentric_weights_top;
    import bw_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [191:0]      s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [95:0]       m_tdata;
    logic [0:0]        m_tuser;

    weight_board board = new();
    int   send_idle;
    int   recv_idle;
    logic hold = 1'b0;
    int   sent;

    barycentric_weights_top dut (.*);

    always #4 clk = ~clk;

    initial
    begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    // receiver: random stalls, held off completely while hold is set
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser[0]);
        if (hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic write_eps(input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_EPS, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        board.eps = val;
    endtask

    task automatic send_word(input logic [191:0] d);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge clk); while (!s_tready);
        board.note_input(d);
        sent++;
    endtask

    task automatic drain();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (board.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [15:0] coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // random triangle: mostly sensible, some collinear or coincident ones
    function automatic logic [191:0] rand_word();
        logic [191:0] d;
        int           kind;
        for (int k = 0; k < 12; k++)
            d[16*k +: 16] = coord();
        kind = $urandom_range(9);
        if (kind == 0)
            d[96 +: 48] = d[48 +: 48];
        else if (kind == 1)
            for (int k = 0; k < 3; k++)
                d[144 + 16*k +: 16] = 16'(2 * $signed(d[96 + 16*k +: 16])
                                          - $signed(d[48 + 16*k +: 16]));
        else if (kind < 5)
            for (int k = 0; k < 12; k++)
                d[16*k +: 16] = 16'($signed($urandom_range(2048)) - 1024);
        return d;
    endfunction

    function automatic logic [191:0] tri_word(input int px, py, pz, ax, ay, az,
                                              bx, by, bz, cx, cy, cz);
        return {16'(cz), 16'(cy), 16'(cx), 16'(bz), 16'(by), 16'(bx),
                16'(az), 16'(ay), 16'(ax), 16'(pz), 16'(py), 16'(px)};
    endfunction

    initial
    begin
        logic [31:0] eps_set[4];
        eps_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0100_0000};
        send_idle = 38; recv_idle = 67; sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unit triangle, inside/outside points, extremes, degenerates
        send_word(tri_word(64, 64, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        send_word(tri_word(-512, 900, 7, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        send_word(tri_word(0, 0, 0, 5, 5, 5, 5, 5, 5, 5, 5, 5));
        send_word(tri_word(1, 2, 3, 0, 0, 0, 1, 1, 1, 2, 2, 2));
        send_word(tri_word(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_word({12{16'h7FFF}});
        send_word({12{16'h8000}});
        send_word(tri_word(32767, -32768, 32767, -32768, -32768, -32768,
                           32767, -32768, -32768, -32768, 32767, -32768));
        send_word(tri_word(-32768, 32767, -32768, 32767, 32767, 32767,
                           -32768, 32767, 32767, 32767, -32768, 32767));
        send_word(tri_word(32767, 32767, 32767, 0, 0, 0, 1, 0, 0, 0, 1, 1));
        send_word(tri_word(-32768, -32768, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_word({192{1'b1}});
        send_word({12{16'h5555}} ^ {6{32'hFFFF_0000}});
        send_word({12{16'hAAAA}} ^ {6{32'h0000_FFFF}});
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_eps(eps_set[ph]);
            if (ph == 1) begin send_idle = 67; recv_idle = 38; end
            if (ph == 2) begin send_idle = 0; recv_idle = 0; end
            if (ph == 3)
            begin
                send_idle = 0; recv_idle = 0;
                // hold the receiver off for a long stretch in its own thread
                fork
                    begin
                        hold <= 1'b1;
                        repeat (300) @(posedge clk);
                        hold <= 1'b0;
                    end
                join_none
            end
            send_word(tri_word(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
            for (int i = 0; i < 110; i++)
                send_word(rand_word());
            drain();
        end
        write_eps(EPS_RESET);
        for (int i = 0; i < 20; i++)
            send_word(rand_word());
        drain();

        $display("covered %0d words, %0d results checked, %0d degenerate",
                 sent, board.checked, board.degen_seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### sim.f
sv/bw_pkg.sv
sv/barycentric_weights_top.sv
sv/bw_checker.sv
test/tb_barycentric_weights_top.sv
